>>> design/qfl_pkg.sv
package qfl_pkg;

    // Fixed-point limits
    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIME_CONSTANT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MASS          = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRAVITY       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INERTIA_X     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INERTIA_Y     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_INERTIA_Z     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROTOR_INERTIA = 3'd6;
    localparam int CFG_W = 31;

    localparam logic [CFG_W-1:0] RST_TIME_CONSTANT = 31'd65536;
    localparam logic [CFG_W-1:0] RST_MASS          = 31'd65536;
    localparam logic [CFG_W-1:0] RST_GRAVITY       = 31'd642908;
    localparam logic [CFG_W-1:0] RST_INERTIA       = 31'd65536;
    localparam logic [CFG_W-1:0] RST_ROTOR_INERTIA = 31'd0;

    // Angle to phase of one turn, 2^32 / (2*pi) scaled
    localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;
    localparam logic signed [31:0] INVALID_COS_GAIN = 32'sd100;

    // Divider
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 37;
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_STEPS-1:0] quot;
        logic                 ovf;
    } div_rsp_t;

    // Cosine table
    localparam int COS_TABLE_BITS = 10;
    localparam int COS_R_W        = COS_TABLE_BITS - 2;
    localparam int COS_ADDR_W     = COS_TABLE_BITS - 1;
    localparam int COS_LUT_DEPTH  = 1 << COS_ADDR_W;
    localparam int COS_QUARTER    = 1 << COS_R_W;
    localparam int COS_VAL_W      = 17;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

    typedef logic [COS_VAL_W-1:0] cos_lut_t [COS_LUT_DEPTH];

    // Entry layout: {want_sin, r}; entries past an eighth of a turn are unused
    function automatic cos_lut_t build_cos_lut();
        cos_lut_t    lut;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] h;
        logic [63:0] v;
        logic        ws;
        for (int i = 0; i < COS_LUT_DEPTH; i++) begin
            r  = 64'(i) & 64'(COS_QUARTER - 1);
            ws = ((i >> COS_R_W) & 1) != 0;
            if (r > 64'(COS_QUARTER / 2)) begin
                lut[i] = '0;
            end
            else begin
                t = (r * TWO_PI_Q30) >> COS_TABLE_BITS;
                u = (t * t) >> 30;
                if (ws) begin
                    h = Q30_ONE - u / 72;
                    h = Q30_ONE - ((u * h) >> 30) / 42;
                    h = Q30_ONE - ((u * h) >> 30) / 20;
                    h = Q30_ONE - ((u * h) >> 30) / 6;
                    v = (t * h) >> 30;
                end
                else begin
                    h = Q30_ONE - u / 90;
                    h = Q30_ONE - ((u * h) >> 30) / 56;
                    h = Q30_ONE - ((u * h) >> 30) / 30;
                    h = Q30_ONE - ((u * h) >> 30) / 12;
                    h = Q30_ONE - ((u * h) >> 30) / 2;
                    v = h;
                end
                v = (v + 64'd8192) >> 14;
                lut[i] = COS_VAL_W'(v);
            end
        end
        return lut;
    endfunction

    localparam cos_lut_t COS_LUT = build_cos_lut();

    // Saturating helpers
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31]) begin
            return s[32] ? INT32_MIN : INT32_MAX;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        if (s[32] != s[31]) begin
            return s[32] ? INT32_MIN : INT32_MAX;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] sat_neg(input logic signed [31:0] a);
        if (a == INT32_MIN) begin
            return INT32_MAX;
        end
        return -a;
    endfunction

    function automatic logic signed [31:0] sat_wide(input logic signed [63:0] p);
        if (p > 64'sd2147483647) begin
            return INT32_MAX;
        end
        if (p < -64'sd2147483648) begin
            return INT32_MIN;
        end
        return p[31:0];
    endfunction

    // Q16.16 product: round to nearest, ties up, then saturate
    function automatic logic signed [31:0] round_q16(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = (p + 64'sd32768) >>> 16;
        return sat_wide(q);
    endfunction

endpackage

>>> design/qfl_div.sv
module qfl_div (
    input  logic              clk,
    input  logic              rst_n,
    input  qfl_pkg::div_req_t req,
    output qfl_pkg::div_rsp_t rsp
);

    logic                              busy_reg;
    logic                              done_reg;
    logic                              ovf_reg;
    logic [qfl_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [qfl_pkg::DIV_DEN_W-1:0]     rem_reg;
    logic [qfl_pkg::DIV_DEN_W-1:0]     den_reg;
    logic [qfl_pkg::DIV_STEPS-1:0]     shreg_reg;
    logic [qfl_pkg::DIV_DEN_W:0]       trial;
    logic                              ge;
    logic                              too_big;

    // Quotient must fit DIV_STEPS bits, else flag overflow
    assign too_big = {{(qfl_pkg::DIV_DEN_W - (qfl_pkg::DIV_NUM_W - qfl_pkg::DIV_STEPS)){1'b0}},
                      req.num[qfl_pkg::DIV_NUM_W-1:qfl_pkg::DIV_STEPS]} >= req.den;
    assign trial   = {rem_reg, shreg_reg[qfl_pkg::DIV_STEPS-1]};
    assign ge      = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (req.start) begin
                ovf_reg <= too_big;
                if (too_big) begin
                    done_reg <= 1'b1;
                end
                else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= qfl_pkg::DIV_CNT_W'(qfl_pkg::DIV_STEPS);
                end
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == qfl_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Restoring division, one quotient bit a cycle
    always_ff @(posedge clk) begin
        if (req.start) begin
            den_reg   <= req.den;
            rem_reg   <= qfl_pkg::DIV_DEN_W'(req.num[qfl_pkg::DIV_NUM_W-1:qfl_pkg::DIV_STEPS]);
            shreg_reg <= req.num[qfl_pkg::DIV_STEPS-1:0];
        end
        else if (busy_reg) begin
            rem_reg   <= ge ? qfl_pkg::DIV_DEN_W'(trial - {1'b0, den_reg})
                            : trial[qfl_pkg::DIV_DEN_W-1:0];
            shreg_reg <= {shreg_reg[qfl_pkg::DIV_STEPS-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = shreg_reg;
    assign rsp.ovf  = ovf_reg;

endmodule

>>> design/qfl_mul.sv
module qfl_mul (
    input  logic               clk,
    input  logic               load,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] prod,
    output logic signed [31:0] res_round,
    output logic signed [31:0] res_sat
);

    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [63:0] prod_reg;

    // Operands registered, then one product register
    always_ff @(posedge clk) begin
        if (load) begin
            a_reg <= a;
            b_reg <= b;
        end
        prod_reg <= a_reg * b_reg;
    end

    assign prod      = prod_reg;
    assign res_round = qfl_pkg::round_q16(prod_reg);
    assign res_sat   = qfl_pkg::sat_wide(prod_reg);

endmodule

>>> design/qfl_cos.sv
module qfl_cos (
    input  logic               clk,
    input  logic               load,
    input  logic [31:0]        phase,
    output logic signed [17:0] cos_val
);

    logic [31:0]                      rnd;
    logic [qfl_pkg::COS_TABLE_BITS-1:0] idx;
    logic [1:0]                       quad;
    logic [qfl_pkg::COS_R_W-1:0]      r;
    logic [qfl_pkg::COS_R_W-1:0]      r_fold;
    logic                             fold;
    logic                             want_sin;
    logic [qfl_pkg::COS_ADDR_W-1:0]   addr;
    logic [qfl_pkg::COS_VAL_W-1:0]    rom_reg;
    logic                             neg_reg;

    assign rnd      = phase + (32'd1 << (31 - qfl_pkg::COS_TABLE_BITS));
    assign idx      = rnd[31:32-qfl_pkg::COS_TABLE_BITS];
    assign quad     = idx[qfl_pkg::COS_TABLE_BITS-1:qfl_pkg::COS_TABLE_BITS-2];
    assign r        = idx[qfl_pkg::COS_R_W-1:0];
    // Past an eighth of a turn, mirror and swap sine for cosine
    assign fold     = r > qfl_pkg::COS_R_W'(qfl_pkg::COS_QUARTER / 2);
    assign r_fold   = fold ? (~r + 1'b1) : r;
    assign want_sin = quad[0] ^ fold;
    assign addr     = {want_sin, r_fold};

    always_ff @(posedge clk) begin
        if (load) begin
            rom_reg <= qfl_pkg::COS_LUT[addr];
            neg_reg <= quad[1] ^ quad[0];
        end
    end

    assign cos_val = neg_reg ? -$signed({1'b0, rom_reg}) : $signed({1'b0, rom_reg});

endmodule

>>> design/quadrotor_feedback_linearization.sv
// Flow: an accepted measurement word runs the multiplier program and, unless a cosine is not
//   positive, the two thrust quotients; the first frame after reset or a register write also
//   recomputes the five gains. A stalled output register holds the result and adds its wait.
// Pace: no new word is taken until the result is in the output register; the shared multiplier
//   and the one-bit-a-cycle divider set the pace. Set-point words are latched while idle.
// Reset: registers return to their defaults, set-points clear, cached gains are invalidated.
module quadrotor_feedback_linearization (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [qfl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [qfl_pkg::CFG_W-1:0]       cfg_wdata,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic signed [31:0]              altitude,
    input  logic signed [31:0]              roll,
    input  logic signed [31:0]              pitch,
    input  logic signed [31:0]              yaw,
    input  logic signed [31:0]              climb_rate,
    input  logic signed [31:0]              roll_rate,
    input  logic signed [31:0]              pitch_rate,
    input  logic signed [31:0]              yaw_rate,
    input  logic signed [31:0]              rotor_speed_sum,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              thrust,
    output logic signed [31:0]              roll_torque,
    output logic signed [31:0]              pitch_torque,
    output logic signed [31:0]              yaw_torque
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV_START, S_DIV_WAIT, S_ISSUE, S_MULT, S_WB, S_COS, S_DONE
    } state_t;

    // Divider jobs: gains first, then the two thrust quotients
    typedef enum logic [2:0] {
        JOB_KP, JOB_KV_ALT, JOB_KV_ROLL, JOB_KV_PITCH, JOB_KV_YAW, JOB_THR_S2, JOB_THR_MG
    } job_t;

    // Multiplier program, one product per step
    typedef enum logic [4:0] {
        M_ALT_S1, M_ALT_S2, M_ROLL_S1, M_ROLL_S2, M_PITCH_S1, M_PITCH_S2,
        M_YAW_S1, M_YAW_S2, M_COS_ROLL, M_COS_PITCH, M_MG, M_DEN,
        M_THR_S2, M_THR_MG, M_ROLL_QR, M_ROLL_K, M_ROLL_QW, M_ROLL_J,
        M_PITCH_PR, M_PITCH_K, M_PITCH_PW, M_PITCH_J, M_YAW_PQ, M_YAW_K
    } mstep_t;

    state_t state_reg;
    job_t   job_reg;
    mstep_t mstep_reg;
    logic   gains_valid_reg;
    logic   out_valid_reg;
    logic signed [31:0] out_thrust_reg;
    logic signed [31:0] out_roll_reg;
    logic signed [31:0] out_pitch_reg;
    logic signed [31:0] out_yaw_reg;

    // configuration registers
    logic [qfl_pkg::CFG_W-1:0] tau_reg;
    logic [qfl_pkg::CFG_W-1:0] mass_reg;
    logic [qfl_pkg::CFG_W-1:0] grav_reg;
    logic [qfl_pkg::CFG_W-1:0] ix_reg;
    logic [qfl_pkg::CFG_W-1:0] iy_reg;
    logic [qfl_pkg::CFG_W-1:0] iz_reg;
    logic [qfl_pkg::CFG_W-1:0] jr_reg;

    // set-point
    logic signed [31:0] sp_alt_reg;
    logic signed [31:0] sp_roll_reg;
    logic signed [31:0] sp_pitch_reg;
    logic signed [31:0] sp_yaw_reg;

    // measurement frame
    logic signed [31:0] m_alt_reg;
    logic signed [31:0] m_roll_reg;
    logic signed [31:0] m_pitch_reg;
    logic signed [31:0] m_yaw_reg;
    logic signed [31:0] climb_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] q_reg;
    logic signed [31:0] r_reg;
    logic signed [31:0] w_reg;

    // gains and working values
    logic signed [31:0] kp_reg;
    logic signed [31:0] kv_alt_reg;
    logic signed [31:0] kv_roll_reg;
    logic signed [31:0] kv_pitch_reg;
    logic signed [31:0] kv_yaw_reg;
    logic signed [31:0] s1_reg;
    logic signed [31:0] s2_alt_reg;
    logic signed [31:0] s2_roll_reg;
    logic signed [31:0] s2_pitch_reg;
    logic signed [31:0] s2_yaw_reg;
    logic signed [17:0] cr_reg;
    logic signed [17:0] cp_reg;
    logic signed [31:0] mg_reg;
    logic [32:0]        den_c_reg;
    logic signed [31:0] thr_a_reg;
    logic signed [31:0] thr_b_reg;
    logic signed [31:0] t1_reg;
    logic signed [31:0] t2_reg;
    logic signed [31:0] roll_cmd_reg;
    logic signed [31:0] pitch_cmd_reg;
    logic signed [31:0] yaw_cmd_reg;

    logic               in_accept;
    logic               bad_cos;
    logic [qfl_pkg::CFG_W-1:0] tau_eff;
    logic [qfl_pkg::DIV_DEN_W-1:0] kp_den;
    logic [qfl_pkg::CFG_W-1:0] kv_num_m;
    logic signed [31:0] thr_x;
    logic [31:0]        thr_mag;
    logic signed [31:0] gain_q;
    logic signed [31:0] thr_q;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_prod;
    logic signed [31:0] mul_round;
    logic signed [31:0] mul_sat;
    logic signed [17:0] cos_val;
    qfl_pkg::div_req_t  div_req;
    qfl_pkg::div_rsp_t  div_rsp;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign bad_cos   = (cr_reg <= 18'sd0) || (cp_reg <= 18'sd0);

    // ---------------------------------------------------------------
    // Divider requests: a zero time constant acts as one LSB
    // ---------------------------------------------------------------
    assign tau_eff = (tau_reg == '0) ? qfl_pkg::CFG_W'(1) : tau_reg;
    assign kp_den  = qfl_pkg::DIV_DEN_W'(tau_eff) * qfl_pkg::DIV_DEN_W'(27);
    assign thr_x   = (job_reg == JOB_THR_MG) ? mg_reg : s2_alt_reg;
    assign thr_mag = thr_x[31] ? 32'(-thr_x) : 32'(thr_x);

    always_comb begin
        kv_num_m = mass_reg;
        unique case (job_reg)
            JOB_KV_ROLL:  kv_num_m = ix_reg;
            JOB_KV_PITCH: kv_num_m = iy_reg;
            JOB_KV_YAW:   kv_num_m = iz_reg;
            default:      kv_num_m = mass_reg;
        endcase
    end

    always_comb begin
        div_req.start = (state_reg == S_DIV_START);
        unique case (job_reg)
            JOB_KP: begin
                div_req.den = kp_den;
                div_req.num = (64'd1 << 33) + 64'(kp_den >> 1);
            end
            JOB_KV_ALT, JOB_KV_ROLL, JOB_KV_PITCH, JOB_KV_YAW: begin
                div_req.den = qfl_pkg::DIV_DEN_W'(tau_eff);
                div_req.num = (64'(kv_num_m) << 14) + 64'(tau_eff >> 1);
            end
            JOB_THR_S2, JOB_THR_MG: begin
                div_req.den = qfl_pkg::DIV_DEN_W'(den_c_reg);
                div_req.num = {thr_mag, 32'd0} + 64'(den_c_reg >> 1);
            end
            default: begin
                div_req.den = '0;
                div_req.num = '0;
            end
        endcase
    end

    // Saturate quotients: positive clamp for gains, signed clamp for thrust
    assign gain_q = (div_rsp.ovf || (div_rsp.quot[32:31] != 2'b00))
                  ? qfl_pkg::INT32_MAX : $signed({1'b0, div_rsp.quot[30:0]});

    always_comb begin
        if (thr_x[31]) begin
            thr_q = (div_rsp.ovf || (div_rsp.quot > 33'h0_8000_0000))
                  ? qfl_pkg::INT32_MIN : $signed(32'(33'd0 - div_rsp.quot));
        end
        else begin
            thr_q = gain_q;
        end
    end

    qfl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------------------------------------------------------
    // Multiplier operand selection per program step
    // ---------------------------------------------------------------
    always_comb begin
        mul_a = kp_reg;
        mul_b = '0;
        unique case (mstep_reg)
            M_ALT_S1:    begin mul_a = kp_reg;       mul_b = qfl_pkg::sat_sub(sp_alt_reg, m_alt_reg); end
            M_ALT_S2:    begin mul_a = kv_alt_reg;   mul_b = qfl_pkg::sat_sub(s1_reg, climb_reg); end
            M_ROLL_S1:   begin mul_a = kp_reg;       mul_b = qfl_pkg::sat_sub(sp_roll_reg, m_roll_reg); end
            M_ROLL_S2:   begin mul_a = kv_roll_reg;  mul_b = qfl_pkg::sat_sub(s1_reg, p_reg); end
            M_PITCH_S1:  begin mul_a = kp_reg;       mul_b = qfl_pkg::sat_sub(sp_pitch_reg, m_pitch_reg); end
            M_PITCH_S2:  begin mul_a = kv_pitch_reg; mul_b = qfl_pkg::sat_sub(s1_reg, q_reg); end
            M_YAW_S1:    begin mul_a = kp_reg;       mul_b = qfl_pkg::sat_sub(sp_yaw_reg, m_yaw_reg); end
            M_YAW_S2:    begin mul_a = kv_yaw_reg;   mul_b = qfl_pkg::sat_sub(s1_reg, r_reg); end
            M_COS_ROLL:  begin mul_a = m_roll_reg;   mul_b = qfl_pkg::INV_TWO_PI_Q32; end
            M_COS_PITCH: begin mul_a = m_pitch_reg;  mul_b = qfl_pkg::INV_TWO_PI_Q32; end
            M_MG:        begin mul_a = $signed({1'b0, mass_reg}); mul_b = $signed({1'b0, grav_reg}); end
            M_DEN:       begin mul_a = 32'(cr_reg);  mul_b = 32'(cp_reg); end
            M_THR_S2:    begin mul_a = s2_alt_reg;   mul_b = qfl_pkg::INVALID_COS_GAIN; end
            M_THR_MG:    begin mul_a = mg_reg;       mul_b = qfl_pkg::INVALID_COS_GAIN; end
            M_ROLL_QR:   begin mul_a = q_reg;        mul_b = r_reg; end
            M_ROLL_K:    begin mul_a = t1_reg;
                               mul_b = $signed({1'b0, iy_reg}) - $signed({1'b0, iz_reg}); end
            M_ROLL_QW:   begin mul_a = q_reg;        mul_b = w_reg; end
            M_ROLL_J:    begin mul_a = t2_reg;       mul_b = $signed({1'b0, jr_reg}); end
            M_PITCH_PR:  begin mul_a = p_reg;        mul_b = r_reg; end
            M_PITCH_K:   begin mul_a = t1_reg;
                               mul_b = $signed({1'b0, iz_reg}) - $signed({1'b0, ix_reg}); end
            M_PITCH_PW:  begin mul_a = p_reg;        mul_b = w_reg; end
            M_PITCH_J:   begin mul_a = t2_reg;       mul_b = $signed({1'b0, jr_reg}); end
            M_YAW_PQ:    begin mul_a = p_reg;        mul_b = q_reg; end
            M_YAW_K:     begin mul_a = t1_reg;
                               mul_b = $signed({1'b0, ix_reg}) - $signed({1'b0, iy_reg}); end
            default:     begin mul_a = '0;           mul_b = '0; end
        endcase
    end

    qfl_mul u_mul (
        .clk       (clk),
        .load      (state_reg == S_ISSUE),
        .a         (mul_a),
        .b         (mul_b),
        .prod      (mul_prod),
        .res_round (mul_round),
        .res_sat   (mul_sat)
    );

    // Phase of one turn sits in bits 47:16 of the angle product
    qfl_cos u_cos (
        .clk     (clk),
        .load    ((state_reg == S_WB) &&
                  ((mstep_reg == M_COS_ROLL) || (mstep_reg == M_COS_PITCH))),
        .phase   (mul_prod[47:16]),
        .cos_val (cos_val)
    );

    // ---------------------------------------------------------------
    // Sequencer, configuration, set-point and output word
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg       <= S_IDLE;
            job_reg         <= JOB_KP;
            mstep_reg       <= M_ALT_S1;
            gains_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_thrust_reg  <= '0;
            out_roll_reg    <= '0;
            out_pitch_reg   <= '0;
            out_yaw_reg     <= '0;
            tau_reg         <= qfl_pkg::RST_TIME_CONSTANT;
            mass_reg        <= qfl_pkg::RST_MASS;
            grav_reg        <= qfl_pkg::RST_GRAVITY;
            ix_reg          <= qfl_pkg::RST_INERTIA;
            iy_reg          <= qfl_pkg::RST_INERTIA;
            iz_reg          <= qfl_pkg::RST_INERTIA;
            jr_reg          <= qfl_pkg::RST_ROTOR_INERTIA;
            sp_alt_reg      <= '0;
            sp_roll_reg     <= '0;
            sp_pitch_reg    <= '0;
            sp_yaw_reg      <= '0;
        end
        else begin
            // drop the output word once taken; a new word in S_DONE takes its place
            if (out_valid_reg && !out_stall && (state_reg != S_DONE)) begin
                out_valid_reg <= 1'b0;
            end

            // any register write invalidates the cached gains
            if (cfg_we) begin
                gains_valid_reg <= 1'b0;
                case (cfg_addr)
                    qfl_pkg::CFG_TIME_CONSTANT: tau_reg  <= cfg_wdata;
                    qfl_pkg::CFG_MASS:          mass_reg <= cfg_wdata;
                    qfl_pkg::CFG_GRAVITY:       grav_reg <= cfg_wdata;
                    qfl_pkg::CFG_INERTIA_X:     ix_reg   <= cfg_wdata;
                    qfl_pkg::CFG_INERTIA_Y:     iy_reg   <= cfg_wdata;
                    qfl_pkg::CFG_INERTIA_Z:     iz_reg   <= cfg_wdata;
                    qfl_pkg::CFG_ROTOR_INERTIA: jr_reg   <= cfg_wdata;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_accept) begin
                        if (!opcode) begin
                            // set-point word: latch and stay idle
                            sp_alt_reg   <= altitude;
                            sp_roll_reg  <= roll;
                            sp_pitch_reg <= pitch;
                            sp_yaw_reg   <= yaw;
                        end
                        else if (gains_valid_reg) begin
                            mstep_reg <= M_ALT_S1;
                            state_reg <= S_ISSUE;
                        end
                        else begin
                            job_reg   <= JOB_KP;
                            state_reg <= S_DIV_START;
                        end
                    end
                end
                S_DIV_START: begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        case (job_reg)
                            JOB_KV_YAW: begin
                                if (!cfg_we) begin
                                    gains_valid_reg <= 1'b1;
                                end
                                mstep_reg       <= M_ALT_S1;
                                state_reg       <= S_ISSUE;
                            end
                            JOB_THR_S2: begin
                                job_reg   <= JOB_THR_MG;
                                state_reg <= S_DIV_START;
                            end
                            JOB_THR_MG: begin
                                mstep_reg <= M_ROLL_QR;
                                state_reg <= S_ISSUE;
                            end
                            default: begin
                                job_reg   <= job_t'(job_reg + 3'd1);
                                state_reg <= S_DIV_START;
                            end
                        endcase
                    end
                end
                S_ISSUE: begin
                    state_reg <= S_MULT;
                end
                S_MULT: begin
                    state_reg <= S_WB;
                end
                S_WB: begin
                    case (mstep_reg)
                        M_COS_ROLL, M_COS_PITCH: begin
                            state_reg <= S_COS;
                        end
                        M_DEN: begin
                            // cosine not positive: multiply by 100 instead of dividing
                            if (bad_cos) begin
                                mstep_reg <= M_THR_S2;
                                state_reg <= S_ISSUE;
                            end
                            else begin
                                job_reg   <= JOB_THR_S2;
                                state_reg <= S_DIV_START;
                            end
                        end
                        M_THR_MG: begin
                            mstep_reg <= M_ROLL_QR;
                            state_reg <= S_ISSUE;
                        end
                        M_YAW_K: begin
                            state_reg <= S_DONE;
                        end
                        default: begin
                            mstep_reg <= mstep_t'(mstep_reg + 5'd1);
                            state_reg <= S_ISSUE;
                        end
                    endcase
                end
                S_COS: begin
                    mstep_reg <= mstep_t'(mstep_reg + 5'd1);
                    state_reg <= S_ISSUE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall) begin
                        out_thrust_reg <= qfl_pkg::sat_add(thr_a_reg, thr_b_reg);
                        out_roll_reg   <= roll_cmd_reg;
                        out_pitch_reg  <= pitch_cmd_reg;
                        out_yaw_reg    <= yaw_cmd_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Working registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk) begin
        if (in_accept && opcode) begin
            m_alt_reg   <= altitude;
            m_roll_reg  <= roll;
            m_pitch_reg <= pitch;
            m_yaw_reg   <= yaw;
            climb_reg   <= climb_rate;
            p_reg       <= roll_rate;
            q_reg       <= pitch_rate;
            r_reg       <= yaw_rate;
            w_reg       <= rotor_speed_sum;
        end

        if ((state_reg == S_DIV_WAIT) && div_rsp.done) begin
            case (job_reg)
                JOB_KP:       kp_reg       <= gain_q;
                JOB_KV_ALT:   kv_alt_reg   <= gain_q;
                JOB_KV_ROLL:  kv_roll_reg  <= gain_q;
                JOB_KV_PITCH: kv_pitch_reg <= gain_q;
                JOB_KV_YAW:   kv_yaw_reg   <= gain_q;
                JOB_THR_S2:   thr_a_reg    <= thr_q;
                JOB_THR_MG:   thr_b_reg    <= thr_q;
                default: ;
            endcase
        end

        if (state_reg == S_WB) begin
            case (mstep_reg)
                M_ALT_S1, M_ROLL_S1, M_PITCH_S1, M_YAW_S1: s1_reg <= mul_round;
                M_ALT_S2:   s2_alt_reg   <= mul_round;
                M_ROLL_S2:  s2_roll_reg  <= mul_round;
                M_PITCH_S2: s2_pitch_reg <= mul_round;
                M_YAW_S2:   s2_yaw_reg   <= mul_round;
                M_MG:       mg_reg       <= mul_round;
                M_DEN:      den_c_reg    <= mul_prod[32:0];
                M_THR_S2:   thr_a_reg    <= mul_sat;
                M_THR_MG:   thr_b_reg    <= mul_sat;
                M_ROLL_QR, M_ROLL_K, M_PITCH_PR, M_PITCH_K, M_YAW_PQ: t1_reg <= mul_round;
                M_ROLL_QW, M_PITCH_PW: t2_reg <= mul_round;
                M_ROLL_J: begin
                    roll_cmd_reg <= qfl_pkg::sat_add(s2_roll_reg,
                                                     qfl_pkg::sat_sub(t1_reg, mul_round));
                end
                M_PITCH_J: begin
                    pitch_cmd_reg <= qfl_pkg::sat_add(qfl_pkg::sat_neg(s2_pitch_reg),
                                                      qfl_pkg::sat_add(t1_reg, mul_round));
                end
                M_YAW_K: begin
                    yaw_cmd_reg <= qfl_pkg::sat_add(s2_yaw_reg, mul_round);
                end
                default: ;
            endcase
        end

        if (state_reg == S_COS) begin
            if (mstep_reg == M_COS_ROLL) begin
                cr_reg <= cos_val;
            end
            else begin
                cp_reg <= cos_val;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign thrust       = out_thrust_reg;
    assign roll_torque  = out_roll_reg;
    assign pitch_torque = out_pitch_reg;
    assign yaw_torque   = out_yaw_reg;

endmodule
